/* hw/rtl/bshh_pkg.sv */
package bshh_pkg;

  // Field widths.
  localparam int TEMP_W     = 12;
  localparam int WEIGHT_W   = 16;
  localparam int DOSE_W     = 12;
  localparam int STRENGTH_W = 4;
  localparam int TOL_W      = 8;
  localparam int TICKS_W    = 8;
  localparam int PHASE_W    = 3;
  localparam int HMODE_W    = 2;
  localparam int ADDR_W     = 5;
  localparam int DATA_W     = 32;
  localparam int REG_IDX_W  = 3;

  // Brew phase codes.
  localparam logic [PHASE_W-1:0] PH_READY    = 3'd0;
  localparam logic [PHASE_W-1:0] PH_HEAT     = 3'd1;
  localparam logic [PHASE_W-1:0] PH_DISPENSE = 3'd2;
  localparam logic [PHASE_W-1:0] PH_BLOOM    = 3'd3;
  localparam logic [PHASE_W-1:0] PH_POUR     = 3'd4;
  localparam logic [PHASE_W-1:0] PH_DONE     = 3'd5;

  // Heater loop codes.
  localparam logic [HMODE_W-1:0] HM_IDLE = 2'd0;
  localparam logic [HMODE_W-1:0] HM_ON   = 2'd1;
  localparam logic [HMODE_W-1:0] HM_OFF  = 2'd2;

  // Register indexes (word address).
  localparam logic [REG_IDX_W-1:0] REG_TARGET_TEMP    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_DOSE_WEIGHT    = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_STRENGTH_RATIO = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_TOLERANCE      = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_BLOOM_TICKS    = 3'd4;

  // Register reset values.
  localparam logic [TEMP_W-1:0]     TARGET_TEMP_RST    = 12'd0;
  localparam logic [DOSE_W-1:0]     DOSE_WEIGHT_RST    = 12'd0;
  localparam logic [STRENGTH_W-1:0] STRENGTH_RATIO_RST = 4'd3;
  localparam logic [TOL_W-1:0]      TOLERANCE_RST      = 8'd20;
  localparam logic [TICKS_W-1:0]    BLOOM_TICKS_RST    = 8'd30;

  typedef struct packed {
    logic [TEMP_W-1:0]     target_temp;
    logic [DOSE_W-1:0]     dose_weight;
    logic [STRENGTH_W-1:0] strength_ratio;
    logic [TOL_W-1:0]      tolerance;
    logic [TICKS_W-1:0]    bloom_ticks;
  } cfg_t;

  typedef struct packed {
    logic [TEMP_W-1:0]          temp_reading;
    logic signed [WEIGHT_W-1:0] weight_reading;
    logic                       start_request;
  } item_t;

  typedef struct packed {
    logic               heater_on;
    logic               pump_on;
    logic               tare_request;
    logic               brew_done;
    logic [PHASE_W-1:0] phase;
  } res_t;

endpackage

/* hw/rtl/bshh_if.sv */
// Tick channel: one control tick per beat.
interface bshh_tick_if import bshh_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [TEMP_W-1:0]          temp_reading;
  logic signed [WEIGHT_W-1:0] weight_reading;
  logic                       start_request;

  modport source (output valid, output temp_reading, output weight_reading,
                  output start_request, input ready);
  modport sink (input valid, input temp_reading, input weight_reading,
                input start_request, output ready);
endinterface

// Result channel: one result per beat.
interface bshh_result_if import bshh_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               heater_on;
  logic               pump_on;
  logic               tare_request;
  logic               brew_done;
  logic [PHASE_W-1:0] phase;

  modport source (output valid, output heater_on, output pump_on, output tare_request,
                  output brew_done, output phase, input ready);
  modport sink (input valid, input heater_on, input pump_on, input tare_request,
                input brew_done, input phase, output ready);
endinterface

/* hw/rtl/bshh_cfg.sv */
module bshh_cfg import bshh_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic                 wr_en;
  logic [REG_IDX_W-1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[ADDR_W-1:2];

  // Register writes in the access phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target_temp    <= TARGET_TEMP_RST;
      cfg.dose_weight    <= DOSE_WEIGHT_RST;
      cfg.strength_ratio <= STRENGTH_RATIO_RST;
      cfg.tolerance      <= TOLERANCE_RST;
      cfg.bloom_ticks    <= BLOOM_TICKS_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_TARGET_TEMP:    cfg.target_temp    <= pwdata[TEMP_W-1:0];
        REG_DOSE_WEIGHT:    cfg.dose_weight    <= pwdata[DOSE_W-1:0];
        REG_STRENGTH_RATIO: cfg.strength_ratio <= pwdata[STRENGTH_W-1:0];
        REG_TOLERANCE:      cfg.tolerance      <= pwdata[TOL_W-1:0];
        REG_BLOOM_TICKS:    cfg.bloom_ticks    <= pwdata[TICKS_W-1:0];
        default: ;
      endcase
    end
  end

  // Read data, zero extended.
  always_comb begin
    case (reg_idx)
      REG_TARGET_TEMP:    prdata = {{(DATA_W-TEMP_W){1'b0}}, cfg.target_temp};
      REG_DOSE_WEIGHT:    prdata = {{(DATA_W-DOSE_W){1'b0}}, cfg.dose_weight};
      REG_STRENGTH_RATIO: prdata = {{(DATA_W-STRENGTH_W){1'b0}}, cfg.strength_ratio};
      REG_TOLERANCE:      prdata = {{(DATA_W-TOL_W){1'b0}}, cfg.tolerance};
      REG_BLOOM_TICKS:    prdata = {{(DATA_W-TICKS_W){1'b0}}, cfg.bloom_ticks};
      default:            prdata = '0;
    endcase
  end

endmodule

/* hw/rtl/bshh_ctrl.sv */
module bshh_ctrl import bshh_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  step,
  input  item_t item,
  input  cfg_t  cfg,
  output res_t  res
);

  // Sequencer and heater state.
  logic [PHASE_W-1:0]         phase;
  logic [HMODE_W-1:0]         heater_mode;
  logic                       heat_demand;
  logic                       pour_active;
  logic                       tare_pending;
  logic [TICKS_W-1:0]         bloom_counter;
  logic signed [WEIGHT_W-1:0] captured_weight;

  logic [PHASE_W-1:0]         phase_next;
  logic [HMODE_W-1:0]         heater_mode_next;
  logic                       heat_demand_next;
  logic                       pour_active_next;
  logic                       tare_pending_next;
  logic [TICKS_W-1:0]         bloom_counter_next;
  logic signed [WEIGHT_W-1:0] captured_weight_next;

  // Phase step results, before the heater loop runs.
  logic [HMODE_W-1:0]         mode_mid;
  logic                       demand_mid;
  logic                       tare_hit;
  logic                       done_hit;
  logic [TICKS_W-1:0]         bloom_inc;

  // Targets in an 18-bit signed domain so that dose * strength fits.
  logic [DOSE_W+STRENGTH_W-1:0] pour_prod;
  logic signed [17:0]           tol_s;
  logic signed [17:0]           dose_lim;
  logic signed [17:0]           bloom_lim;
  logic signed [17:0]           pour_lim;
  logic signed [WEIGHT_W-1:0]   cmp_w;
  logic signed [17:0]           cmp_w_s;
  logic signed [TEMP_W:0]       temp_lim;
  logic                         temp_ok;

  assign pour_prod = cfg.dose_weight * cfg.strength_ratio;
  assign tol_s     = signed'({10'd0, cfg.tolerance});
  assign dose_lim  = signed'({6'd0, cfg.dose_weight}) - tol_s;
  assign bloom_lim = signed'({5'd0, cfg.dose_weight, 1'b0}) - tol_s;
  assign pour_lim  = signed'({2'd0, pour_prod}) - tol_s;

  // A pending tare captures this tick's weight before the compare.
  assign cmp_w   = tare_pending ? item.weight_reading : captured_weight;
  assign cmp_w_s = {{2{cmp_w[WEIGHT_W-1]}}, cmp_w};

  assign temp_lim = signed'({1'b0, cfg.target_temp}) - signed'({5'd0, cfg.tolerance});
  assign temp_ok  = signed'({1'b0, item.temp_reading}) >= temp_lim;

  assign bloom_inc = (bloom_counter != {TICKS_W{1'b1}}) ? bloom_counter + 1'b1
                                                         : bloom_counter;

  // Brew phase step.
  always_comb begin
    phase_next           = phase;
    mode_mid             = heater_mode;
    demand_mid           = heat_demand;
    pour_active_next     = pour_active;
    tare_pending_next    = tare_pending;
    bloom_counter_next   = bloom_counter;
    captured_weight_next = captured_weight;
    tare_hit             = 1'b0;
    done_hit             = 1'b0;
    case (phase)
      PH_READY: begin
        mode_mid             = HM_IDLE;
        demand_mid           = item.start_request;
        pour_active_next     = 1'b0;
        tare_pending_next    = 1'b1;
        captured_weight_next = '0;
        bloom_counter_next   = '0;
        if (item.start_request) begin
          phase_next = PH_HEAT;
        end
      end
      PH_HEAT: begin
        if (!heat_demand) begin
          phase_next = PH_DISPENSE;
        end
      end
      PH_DISPENSE: begin
        tare_hit             = tare_pending;
        tare_pending_next    = 1'b0;
        captured_weight_next = cmp_w;
        if (cmp_w_s < dose_lim) begin
          captured_weight_next = item.weight_reading;
        end else begin
          phase_next        = PH_BLOOM;
          tare_pending_next = 1'b1;
        end
      end
      PH_BLOOM: begin
        tare_hit             = tare_pending;
        tare_pending_next    = 1'b0;
        captured_weight_next = cmp_w;
        bloom_counter_next   = bloom_inc;
        pour_active_next     = cmp_w_s < bloom_lim;
        if (cmp_w_s < bloom_lim) begin
          captured_weight_next = item.weight_reading;
        end
        if (bloom_inc >= cfg.bloom_ticks) begin
          phase_next        = PH_POUR;
          tare_pending_next = 1'b1;
        end
      end
      PH_POUR: begin
        tare_hit             = tare_pending;
        tare_pending_next    = 1'b0;
        captured_weight_next = cmp_w;
        pour_active_next     = 1'b1;
        if (cmp_w_s < pour_lim) begin
          captured_weight_next = item.weight_reading;
        end else begin
          pour_active_next = 1'b0;
          phase_next       = PH_DONE;
        end
      end
      PH_DONE: begin
        done_hit   = 1'b1;
        phase_next = PH_READY;
      end
      default: ;
    endcase
  end

  // Hysteresis heater loop, after the phase step.
  always_comb begin
    heater_mode_next = mode_mid;
    heat_demand_next = demand_mid;
    case (mode_mid)
      HM_IDLE: begin
        if (demand_mid) begin
          heater_mode_next = HM_ON;
        end
      end
      HM_ON: begin
        heat_demand_next = !temp_ok;
        if (temp_ok) begin
          heater_mode_next = HM_OFF;
        end
      end
      HM_OFF: begin
        heat_demand_next = !temp_ok;
        if (!temp_ok) begin
          heater_mode_next = HM_ON;
        end
      end
      default: ;
    endcase
  end

  // Result of the tick being stepped.
  always_comb begin
    res.heater_on    = heat_demand_next;
    res.pump_on      = pour_active_next;
    res.tare_request = tare_hit;
    res.brew_done    = done_hit;
    res.phase        = phase;
  end

  // State update once per stepped tick.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_READY;
      heater_mode     <= HM_IDLE;
      heat_demand     <= 1'b0;
      pour_active     <= 1'b0;
      tare_pending    <= 1'b1;
      bloom_counter   <= '0;
      captured_weight <= '0;
    end else if (step) begin
      phase           <= phase_next;
      heater_mode     <= heater_mode_next;
      heat_demand     <= heat_demand_next;
      pour_active     <= pour_active_next;
      tare_pending    <= tare_pending_next;
      bloom_counter   <= bloom_counter_next;
      captured_weight <= captured_weight_next;
    end
  end

  // The heater demand always tracks the ON mode of the loop.
  a_demand_tracks_mode: assert property (@(posedge clk) disable iff (rst)
    heat_demand == (heater_mode == HM_ON))
    else $error("heat demand out of step with heater mode");

  // A done tick always returns the sequence to ready.
  a_done_to_ready: assert property (@(posedge clk) disable iff (rst)
    step && phase == PH_DONE |=> phase == PH_READY)
    else $error("done phase did not return to ready");

  // A ready tick rearms the tare and clears the captured weight.
  a_ready_rearms: assert property (@(posedge clk) disable iff (rst)
    step && phase == PH_READY |=> tare_pending && captured_weight == '0)
    else $error("ready phase did not rearm tare");

  // The pump only runs in bloom or pour.
  a_pump_phase: assert property (@(posedge clk) disable iff (rst)
    step && res.pump_on |-> phase == PH_BLOOM || phase == PH_POUR)
    else $error("pump driven outside bloom or pour");

endmodule

/* hw/rtl/brew_sequencer_with_heater_hysteresis_core.sv */
// A tick beat is held in the tick register and stepped into the result register once
// that one is free. Throughput: one tick per cycle while result.ready stays high; the
// state loop in the control stage closes between the tick register and the result register.
// Reset (rst, synchronous, active high) returns the sequence to ready, the heater
// to idle, arms the tare and loads the configuration registers with their defaults.
// No clearing pass follows reset.
module brew_sequencer_with_heater_hysteresis_core import bshh_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  bshh_tick_if.sink             tick,
  bshh_result_if.source         result,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_W-1:0]     paddr,
  input  logic [DATA_W-1:0]     pwdata,
  output logic [DATA_W-1:0]     prdata,
  output logic                  pready
);

  cfg_t  cfg;
  item_t s1_item;
  logic  s1_valid;
  res_t  res;
  res_t  res_q;
  logic  res_valid;
  logic  adv;

  bshh_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // The tick register moves into the result register when that one is free.
  assign adv        = s1_valid && (!res_valid || result.ready);
  assign tick.ready = !s1_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (tick.valid && tick.ready) begin
      s1_valid <= 1'b1;
    end else if (adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick.valid && tick.ready) begin
      s1_item.temp_reading   <= tick.temp_reading;
      s1_item.weight_reading <= tick.weight_reading;
      s1_item.start_request  <= tick.start_request;
    end
  end

  bshh_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .step (adv),
    .item (s1_item),
    .cfg  (cfg),
    .res  (res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_q <= res;
    end
  end

  assign result.valid        = res_valid;
  assign result.heater_on    = res_q.heater_on;
  assign result.pump_on      = res_q.pump_on;
  assign result.tare_request = res_q.tare_request;
  assign result.brew_done    = res_q.brew_done;
  assign result.phase        = res_q.phase;

endmodule
